### src/assert_macros.svh
// assertion macros shared by the triangle element matrix rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TEM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TEM_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define TEM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TEM_ASSERT(label, clk, rst_n, prop, msg)
`define TEM_ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`define TEM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### src/tem_pkg.sv
// types, widths and helper functions of the triangle element matrix block
package tem_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned DIFF_W      = 34;
  localparam int unsigned SUM_W       = 34;
  localparam int unsigned NUM_W       = 68;
  localparam int unsigned MAG_W       = 67;
  localparam int unsigned DEN_W       = 66;
  localparam int unsigned QUO_W       = 33;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned STIFF_W     = 32;
  localparam int unsigned MASS_W      = 48;
  localparam int unsigned N_STIFF     = 6;
  localparam int unsigned N_AXIS      = 2;
  localparam int unsigned DIV_STEPS   = QUO_W;
  localparam int unsigned MASS_STEPS  = MASS_W / 2;
  localparam int unsigned CENT_STEPS  = SUM_W / 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned K_AA = 0;
  localparam int unsigned K_AB = 1;
  localparam int unsigned K_AC = 2;
  localparam int unsigned K_BB = 3;
  localparam int unsigned K_BC = 4;
  localparam int unsigned K_CC = 5;

  localparam int unsigned AX_X = 0;
  localparam int unsigned AX_Y = 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_first;
    logic signed [COORD_W-1:0] y_first;
    logic signed [COORD_W-1:0] x_second;
    logic signed [COORD_W-1:0] y_second;
    logic signed [COORD_W-1:0] x_third;
    logic signed [COORD_W-1:0] y_third;
  } tem_in_t;

  typedef struct packed {
    logic signed [STIFF_W-1:0] stiff_aa;
    logic signed [STIFF_W-1:0] stiff_ab;
    logic signed [STIFF_W-1:0] stiff_ac;
    logic signed [STIFF_W-1:0] stiff_bb;
    logic signed [STIFF_W-1:0] stiff_bc;
    logic signed [STIFF_W-1:0] stiff_cc;
    logic signed [MASS_W-1:0]  mass_diag;
    logic signed [MASS_W-1:0]  mass_off;
    logic signed [MASS_W-1:0]  mass_lumped;
    logic signed [MASS_W-1:0]  signed_area;
    logic signed [STIFF_W-1:0] center_x;
    logic signed [STIFF_W-1:0] center_y;
  } tem_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [DEN_W-1:0]                den;
    logic                            det_zero;
    logic                            det_neg;
    logic [N_STIFF-1:0]              num_neg;
    logic [N_STIFF-1:0][MAG_W-1:0]   num_mag;
    logic [N_AXIS-1:0]               sum_neg;
    logic [N_AXIS-1:0][SUM_W-1:0]    sum_mag;
  } tem_work_t;

  // one stage of the back pipeline
  typedef struct packed {
    logic [DEN_W-1:0]                den;
    logic                            det_zero;
    logic                            det_neg;
    logic [N_STIFF-1:0]              res_neg;
    logic [N_STIFF-1:0]              ovf;
    logic [N_STIFF-1:0][DEN_W-1:0]   rem;
    logic [N_STIFF-1:0][QUO_W-1:0]   quo;
    logic [1:0]                      mass_rem;
    logic [MASS_W-1:0]               mass_quo;
    logic [MASS_W-1:0]               area;
    logic [N_AXIS-1:0][1:0]          sum_rem;
    logic [N_AXIS-1:0][SUM_W-1:0]    sum_quo;
    logic [N_AXIS-1:0]               sum_neg;
  } tem_lane_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tem_qstat_t;

  // two dividend bits through a divide by three, returns {quotient bits, remainder}
  function automatic logic [3:0] div3_step(input logic [1:0] rem, input logic [1:0] bits);
    logic [3:0] v;
    v = {rem, bits};
    case (v)
      4'd0:    return {2'd0, 2'd0};
      4'd1:    return {2'd0, 2'd1};
      4'd2:    return {2'd0, 2'd2};
      4'd3:    return {2'd1, 2'd0};
      4'd4:    return {2'd1, 2'd1};
      4'd5:    return {2'd1, 2'd2};
      4'd6:    return {2'd2, 2'd0};
      4'd7:    return {2'd2, 2'd1};
      4'd8:    return {2'd2, 2'd2};
      4'd9:    return {2'd3, 2'd0};
      4'd10:   return {2'd3, 2'd1};
      4'd11:   return {2'd3, 2'd2};
      default: return {2'd0, 2'd0};
    endcase
  endfunction

  function automatic logic [STIFF_W-1:0] sat_stiff(input logic [QUO_W-1:0] quo,
                                                   input logic ovf, input logic neg);
    if (!neg) begin
      if (ovf || quo[QUO_W-1] || quo[STIFF_W-1]) return {1'b0, {(STIFF_W-1){1'b1}}};
      return quo[STIFF_W-1:0];
    end
    if (ovf || quo[QUO_W-1] || (quo[STIFF_W-1] && (|quo[STIFF_W-2:0])))
      return {1'b1, {(STIFF_W-1){1'b0}}};
    return ~quo[STIFF_W-1:0] + 1'b1;
  endfunction

  function automatic logic [MASS_W-1:0] sat_mass(input logic [MASS_W-1:0] mag,
                                                 input logic neg);
    if (!neg) begin
      if (mag[MASS_W-1]) return {1'b0, {(MASS_W-1){1'b1}}};
      return mag;
    end
    if (mag[MASS_W-1] && (|mag[MASS_W-2:0])) return {1'b1, {(MASS_W-1){1'b0}}};
    return ~mag + 1'b1;
  endfunction

endpackage

### src/tem_front.sv
// front pipeline: edge vectors, products, numerators, determinant and classification
module tem_front #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tem_pkg::tem_in_t     in_data,
  output logic                 push,
  output tem_pkg::tem_work_t   push_data,
  input  tem_pkg::tem_qstat_t  qstat
);

  localparam int unsigned CU = (COORD_WIDTH < tem_pkg::COORD_W) ? COORD_WIDTH
                                                               : tem_pkg::COORD_W;
  localparam int unsigned EXT_W = tem_pkg::DIFF_W - CU;

  localparam int unsigned N_DIFF = 8;
  localparam int unsigned DA = 0, DB = 1, DC = 2, DD = 3;
  localparam int unsigned DAMB = 4, DCMD = 5, DBMA = 6, DDMC = 7;

  localparam int unsigned N_PROD = 14;
  localparam int unsigned P_AD = 0, P_BC = 1, P_AMBAMB = 2, P_CMDCMD = 3;
  localparam int unsigned P_AMBB = 4, P_CMDD = 5, P_ABMA = 6, P_CDMC = 7;
  localparam int unsigned P_BB = 8, P_DD = 9, P_AB = 10, P_CD = 11;
  localparam int unsigned P_AA = 12, P_CC = 13;

  logic [3:0] vld_r;
  logic       en;

  logic signed [tem_pkg::DIFF_W-1:0] diff_r    [N_DIFF];
  logic signed [tem_pkg::DIFF_W-1:0] diff_nxt  [N_DIFF];
  logic signed [tem_pkg::SUM_W-1:0]  sum1_r    [tem_pkg::N_AXIS];
  logic signed [tem_pkg::SUM_W-1:0]  sum1_nxt  [tem_pkg::N_AXIS];
  logic signed [tem_pkg::NUM_W-1:0]  prod_r    [N_PROD];
  logic signed [tem_pkg::NUM_W-1:0]  prod_nxt  [N_PROD];
  logic signed [tem_pkg::SUM_W-1:0]  sum2_r    [tem_pkg::N_AXIS];
  logic signed [tem_pkg::NUM_W-1:0]  num_r     [tem_pkg::N_STIFF];
  logic signed [tem_pkg::NUM_W-1:0]  num_nxt   [tem_pkg::N_STIFF];
  logic signed [tem_pkg::NUM_W-1:0]  det_r;
  logic signed [tem_pkg::NUM_W-1:0]  det_nxt;
  logic signed [tem_pkg::SUM_W-1:0]  sum3_r    [tem_pkg::N_AXIS];
  tem_pkg::tem_work_t                work_r;
  tem_pkg::tem_work_t                work_nxt;

  assign en        = !vld_r[3] || !qstat.full;
  assign in_ready  = en;
  assign push      = vld_r[3] && !qstat.full;
  assign push_data = work_r;

  // edge differences and coordinate sums
  always_comb begin
    logic signed [tem_pkg::DIFF_W-1:0] x1, y1, x2, y2, x3, y3;
    x1 = $signed({{EXT_W{in_data.x_first[CU-1]}},  in_data.x_first[CU-1:0]});
    y1 = $signed({{EXT_W{in_data.y_first[CU-1]}},  in_data.y_first[CU-1:0]});
    x2 = $signed({{EXT_W{in_data.x_second[CU-1]}}, in_data.x_second[CU-1:0]});
    y2 = $signed({{EXT_W{in_data.y_second[CU-1]}}, in_data.y_second[CU-1:0]});
    x3 = $signed({{EXT_W{in_data.x_third[CU-1]}},  in_data.x_third[CU-1:0]});
    y3 = $signed({{EXT_W{in_data.y_third[CU-1]}},  in_data.y_third[CU-1:0]});
    diff_nxt[DA]   = x2 - x1;
    diff_nxt[DB]   = x3 - x1;
    diff_nxt[DC]   = y2 - y1;
    diff_nxt[DD]   = y3 - y1;
    diff_nxt[DAMB] = x2 - x3;
    diff_nxt[DCMD] = y2 - y3;
    diff_nxt[DBMA] = x3 - x2;
    diff_nxt[DDMC] = y3 - y2;
    sum1_nxt[tem_pkg::AX_X] = x1 + x2 + x3;
    sum1_nxt[tem_pkg::AX_Y] = y1 + y2 + y3;
  end

  always_comb begin
    prod_nxt[P_AD]     = diff_r[DA]   * diff_r[DD];
    prod_nxt[P_BC]     = diff_r[DB]   * diff_r[DC];
    prod_nxt[P_AMBAMB] = diff_r[DAMB] * diff_r[DAMB];
    prod_nxt[P_CMDCMD] = diff_r[DCMD] * diff_r[DCMD];
    prod_nxt[P_AMBB]   = diff_r[DAMB] * diff_r[DB];
    prod_nxt[P_CMDD]   = diff_r[DCMD] * diff_r[DD];
    prod_nxt[P_ABMA]   = diff_r[DA]   * diff_r[DBMA];
    prod_nxt[P_CDMC]   = diff_r[DC]   * diff_r[DDMC];
    prod_nxt[P_BB]     = diff_r[DB]   * diff_r[DB];
    prod_nxt[P_DD]     = diff_r[DD]   * diff_r[DD];
    prod_nxt[P_AB]     = diff_r[DA]   * diff_r[DB];
    prod_nxt[P_CD]     = diff_r[DC]   * diff_r[DD];
    prod_nxt[P_AA]     = diff_r[DA]   * diff_r[DA];
    prod_nxt[P_CC]     = diff_r[DC]   * diff_r[DC];
  end

  always_comb begin
    det_nxt                   = prod_r[P_AD] - prod_r[P_BC];
    num_nxt[tem_pkg::K_AA]    = prod_r[P_AMBAMB] + prod_r[P_CMDCMD];
    num_nxt[tem_pkg::K_AB]    = prod_r[P_AMBB] + prod_r[P_CMDD];
    num_nxt[tem_pkg::K_AC]    = prod_r[P_ABMA] + prod_r[P_CDMC];
    num_nxt[tem_pkg::K_BB]    = prod_r[P_BB] + prod_r[P_DD];
    num_nxt[tem_pkg::K_BC]    = -prod_r[P_AB] - prod_r[P_CD];
    num_nxt[tem_pkg::K_CC]    = prod_r[P_AA] + prod_r[P_CC];
  end

  // magnitudes, signs and degenerate flag
  always_comb begin
    logic signed [tem_pkg::NUM_W-1:0] mag;
    logic signed [tem_pkg::SUM_W-1:0] smag;
    for (int k = 0; k < tem_pkg::N_STIFF; k++) begin
      mag                  = num_r[k][tem_pkg::NUM_W-1] ? -num_r[k] : num_r[k];
      work_nxt.num_neg[k]  = num_r[k][tem_pkg::NUM_W-1];
      work_nxt.num_mag[k]  = mag[tem_pkg::MAG_W-1:0];
    end
    mag               = det_r[tem_pkg::NUM_W-1] ? -det_r : det_r;
    work_nxt.det_neg  = det_r[tem_pkg::NUM_W-1];
    work_nxt.det_zero = (det_r == '0);
    work_nxt.den      = {mag[tem_pkg::DEN_W-2:0], 1'b0};
    for (int j = 0; j < tem_pkg::N_AXIS; j++) begin
      smag                = sum3_r[j][tem_pkg::SUM_W-1] ? -sum3_r[j] : sum3_r[j];
      work_nxt.sum_neg[j] = sum3_r[j][tem_pkg::SUM_W-1];
      work_nxt.sum_mag[j] = smag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      sum1_r <= sum1_nxt;
      prod_r <= prod_nxt;
      sum2_r <= sum1_r;
      num_r  <= num_nxt;
      det_r  <= det_nxt;
      sum3_r <= sum2_r;
      work_r <= work_nxt;
    end
  end

endmodule

### src/tem_queue.sv
// short request queue between front and back
`include "assert_macros.svh"

module tem_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tem_pkg::tem_work_t   push_data,
  input  logic                 pop,
  output tem_pkg::tem_work_t   head,
  output tem_pkg::tem_qstat_t  qstat
);

  tem_pkg::tem_work_t               mem_r [tem_pkg::QUEUE_DEPTH];
  logic [tem_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [tem_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [tem_pkg::QCNT_W-1:0]       count_r, count_nxt;

  assign qstat.full  = (count_r == tem_pkg::QCNT_W'(tem_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == tem_pkg::QPTR_W'(tem_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == tem_pkg::QPTR_W'(tem_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `TEM_ASSERT(a_count_bound, clk, rst_n, count_r <= tem_pkg::QCNT_W'(tem_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `TEM_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, !qstat.empty, "pop from empty queue")
  `TEM_ASSERT_IMPL(a_push_notfull, clk, rst_n, push, !qstat.full, "push into full queue")

endmodule

### src/tem_back.sv
// back pipeline: restoring dividers for stiffness, divide by three for mass and centroid
`include "assert_macros.svh"

module tem_back (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 pop,
  input  tem_pkg::tem_work_t   head,
  input  tem_pkg::tem_qstat_t  qstat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tem_pkg::tem_out_t    out_data
);

  localparam int unsigned LAST = tem_pkg::DIV_STEPS;
  localparam int unsigned SHR  = tem_pkg::QUO_W - tem_pkg::FRAC_W;

  logic                      en;
  logic [LAST:0]             vld_r;
  tem_pkg::tem_lane_t        stage_r   [0:LAST];
  tem_pkg::tem_lane_t        stage_nxt [0:LAST];
  logic                      out_vld_r;
  tem_pkg::tem_out_t         out_r, out_nxt;

  assign en        = !out_vld_r || out_ready;
  assign pop       = en && !qstat.empty;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    tem_pkg::tem_lane_t       lane;
    logic [tem_pkg::DEN_W:0]  trial;
    logic [3:0]               d3;
    // load and overflow check
    lane          = stage_r[0];
    lane.den      = head.den;
    lane.det_zero = head.det_zero;
    lane.det_neg  = head.det_neg;
    for (int k = 0; k < tem_pkg::N_STIFF; k++) begin
      lane.res_neg[k] = head.num_neg[k] ^ head.det_neg;
      lane.rem[k]     = tem_pkg::DEN_W'(head.num_mag[k][tem_pkg::MAG_W-1:SHR]);
      lane.ovf[k]     = (tem_pkg::DEN_W'(head.num_mag[k][tem_pkg::MAG_W-1:SHR]) >= head.den);
      lane.quo[k]     = {head.num_mag[k][SHR-1:0], {tem_pkg::FRAC_W{1'b0}}};
    end
    lane.mass_rem = '0;
    lane.mass_quo = head.den[tem_pkg::DEN_W-1:tem_pkg::DEN_W-tem_pkg::MASS_W];
    lane.area     = head.den[tem_pkg::DEN_W-1:tem_pkg::DEN_W-tem_pkg::MASS_W];
    lane.sum_rem  = '0;
    lane.sum_quo  = head.sum_mag;
    lane.sum_neg  = head.sum_neg;
    stage_nxt[0]  = lane;
    // one quotient bit per stage
    for (int s = 1; s <= LAST; s++) begin
      lane = stage_r[s-1];
      for (int k = 0; k < tem_pkg::N_STIFF; k++) begin
        trial = {lane.rem[k], lane.quo[k][tem_pkg::QUO_W-1]};
        if (trial >= {1'b0, lane.den}) begin
          trial       = trial - {1'b0, lane.den};
          lane.quo[k] = {lane.quo[k][tem_pkg::QUO_W-2:0], 1'b1};
        end else begin
          lane.quo[k] = {lane.quo[k][tem_pkg::QUO_W-2:0], 1'b0};
        end
        lane.rem[k] = trial[tem_pkg::DEN_W-1:0];
      end
      if (s <= tem_pkg::MASS_STEPS) begin
        d3 = tem_pkg::div3_step(lane.mass_rem,
                                lane.mass_quo[tem_pkg::MASS_W-1:tem_pkg::MASS_W-2]);
        lane.mass_quo = {lane.mass_quo[tem_pkg::MASS_W-3:0], d3[3:2]};
        lane.mass_rem = d3[1:0];
      end
      if (s <= tem_pkg::CENT_STEPS) begin
        for (int j = 0; j < tem_pkg::N_AXIS; j++) begin
          d3 = tem_pkg::div3_step(lane.sum_rem[j],
                                  lane.sum_quo[j][tem_pkg::SUM_W-1:tem_pkg::SUM_W-2]);
          lane.sum_quo[j] = {lane.sum_quo[j][tem_pkg::SUM_W-3:0], d3[3:2]};
          lane.sum_rem[j] = d3[1:0];
        end
      end
      stage_nxt[s] = lane;
    end
  end

  always_comb begin
    logic [tem_pkg::STIFF_W-1:0] st [tem_pkg::N_STIFF];
    logic [tem_pkg::STIFF_W-1:0] cen [tem_pkg::N_AXIS];
    for (int k = 0; k < tem_pkg::N_STIFF; k++) begin
      st[k] = stage_r[LAST].det_zero ? '0
            : tem_pkg::sat_stiff(stage_r[LAST].quo[k], stage_r[LAST].ovf[k],
                                 stage_r[LAST].res_neg[k]);
    end
    for (int j = 0; j < tem_pkg::N_AXIS; j++) begin
      cen[j] = stage_r[LAST].sum_neg[j]
             ? ~stage_r[LAST].sum_quo[j][tem_pkg::STIFF_W-1:0] + 1'b1
             : stage_r[LAST].sum_quo[j][tem_pkg::STIFF_W-1:0];
    end
    out_nxt.stiff_aa    = st[tem_pkg::K_AA];
    out_nxt.stiff_ab    = st[tem_pkg::K_AB];
    out_nxt.stiff_ac    = st[tem_pkg::K_AC];
    out_nxt.stiff_bb    = st[tem_pkg::K_BB];
    out_nxt.stiff_bc    = st[tem_pkg::K_BC];
    out_nxt.stiff_cc    = st[tem_pkg::K_CC];
    out_nxt.mass_lumped = tem_pkg::sat_mass(stage_r[LAST].mass_quo, stage_r[LAST].det_neg);
    out_nxt.mass_diag   = tem_pkg::sat_mass({1'b0, stage_r[LAST].mass_quo[tem_pkg::MASS_W-1:1]},
                                            stage_r[LAST].det_neg);
    out_nxt.mass_off    = tem_pkg::sat_mass({2'b0, stage_r[LAST].mass_quo[tem_pkg::MASS_W-1:2]},
                                            stage_r[LAST].det_neg);
    out_nxt.signed_area = tem_pkg::sat_mass(stage_r[LAST].area, stage_r[LAST].det_neg);
    out_nxt.center_x    = cen[tem_pkg::AX_X];
    out_nxt.center_y    = cen[tem_pkg::AX_Y];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[LAST-1:0], !qstat.empty};
      out_vld_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
      out_r   <= out_nxt;
    end
  end

  `TEM_ASSERT_NEXT(a_pop_loads, clk, rst_n, pop, vld_r[0], "popped request not loaded")
  `TEM_ASSERT_IMPL(a_degenerate_mass, clk, rst_n, vld_r[LAST] && stage_r[LAST].det_zero, stage_r[LAST].mass_quo == '0 && stage_r[LAST].area == '0, "zero determinant with nonzero mass")

endmodule

### src/triangle_element_matrices.sv
// Linear triangle element matrices: takes one triangle per cycle while in_ready is high
// and returns stiffness, mass, area and centroid one result per triangle, in order. A
// four-stage front forms edge vectors, products, numerators and the determinant, then
// feeds a four-entry queue; the back runs six 33-stage restoring dividers (one quotient
// bit per stage) beside bit-pair divide-by-three lanes for mass and centroid. Sustained
// rate is one triangle per clock while out_ready stays high.
// COORD_WIDTH selects how many low bits of each coordinate are used (sign extended,
// at most 32).
module triangle_element_matrices #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tem_pkg::tem_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tem_pkg::tem_out_t  out_data
);

  logic                 push;
  logic                 pop;
  tem_pkg::tem_work_t   push_data;
  tem_pkg::tem_work_t   head;
  tem_pkg::tem_qstat_t  qstat;

  tem_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .qstat     (qstat)
  );

  tem_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  tem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
